FILE: sv/ccv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccv_pkg
// Shared types, constants and helper functions of the coordinate converter.
// ----------------------------------------------------------------------------
package ccv_pkg;

  localparam int COORD_W     = 32;
  localparam int CORDIC_ITER = 24;
  localparam int IW          = 64;           // internal length width
  localparam int GUARD       = 60 - COORD_W; // extra fraction bits
  localparam int ANG_W       = 32;           // internal angle, 2^32 per turn
  localparam int ANG_SH      = (COORD_W >= ANG_W) ? COORD_W - ANG_W : ANG_W - COORD_W;

  localparam logic [ANG_W-1:0] HALF_TURN    = ANG_W'(1) << (ANG_W - 1);
  localparam logic [ANG_W-1:0] QUARTER_TURN = ANG_W'(1) << (ANG_W - 2);
  localparam logic [31:0]      INV_GAIN     = 32'h9B74EDA8;

  localparam logic signed [IW-1:0] LEN_HALF = IW'(1) << (GUARD - 1);
  localparam logic signed [IW-1:0] LEN_MAX  = (IW'(1) << (COORD_W - 1)) - IW'(1);
  localparam logic signed [IW-1:0] LEN_MIN  = -LEN_MAX - IW'(1);

  localparam logic [1:0] CMD_CART_POLAR  = 2'd0;
  localparam logic [1:0] CMD_POLAR_CART  = 2'd1;
  localparam logic [1:0] CMD_CART_SPHER  = 2'd2;
  localparam logic [1:0] CMD_SPHER_CART  = 2'd3;

  typedef struct packed {
    logic [1:0]                cmd;
    logic signed [COORD_W-1:0] in_a;
    logic signed [COORD_W-1:0] in_b;
    logic signed [COORD_W-1:0] in_c;
  } ccv_req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_a;
    logic signed [COORD_W-1:0] out_b;
    logic signed [COORD_W-1:0] out_c;
    logic                      overflow;
  } ccv_rsp_t;

  // item as it travels down the pipeline
  typedef struct packed {
    logic [1:0]           cmd;
    logic                 rot;   // rotation mode, else vectoring
    logic                 zero;  // vectoring of a zero vector
    logic signed [IW-1:0] x;
    logic signed [IW-1:0] y;
    logic [ANG_W-1:0]     ang;
    logic signed [IW-1:0] sx;    // first pass results kept for the end
    logic signed [IW-1:0] sy;
    logic [ANG_W-1:0]     sth;
    logic [COORD_W-1:0]   pb;
    logic [COORD_W-1:0]   pc;
  } ccv_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] val;
    logic                      ovf;
  } ccv_len_t;

  function automatic logic [ANG_W-1:0] atan_val(input int i);
    logic [ANG_W-1:0] r;
    case (i)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051E;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A30;
      19: r = 32'h00000518;
      20: r = 32'h0000028C;
      21: r = 32'h00000146;
      22: r = 32'h000000A3;
      23: r = 32'h00000051;
      24: r = 32'h00000029;
      25: r = 32'h00000014;
      26: r = 32'h0000000A;
      27: r = 32'h00000005;
      28: r = 32'h00000003;
      29: r = 32'h00000001;
      30: r = 32'h00000001;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [IW-1:0] len_in(input logic [COORD_W-1:0] w);
    logic signed [IW-1:0] e;
    e = IW'(signed'(w));
    return e <<< GUARD;
  endfunction

  function automatic ccv_len_t len_out(input logic signed [IW-1:0] v);
    logic signed [IW-1:0] r;
    ccv_len_t o;
    r = (v + LEN_HALF) >>> GUARD;
    o.ovf = 1'b0;
    o.val = COORD_W'(r);
    if (r > LEN_MAX) begin
      o.val = COORD_W'(LEN_MAX);
      o.ovf = 1'b1;
    end else if (r < LEN_MIN) begin
      o.val = COORD_W'(LEN_MIN);
      o.ovf = 1'b1;
    end
    return o;
  endfunction

  function automatic logic [ANG_W-1:0] ang_in(input logic [COORD_W-1:0] w);
    logic [ANG_W-1:0] r;
    if (COORD_W >= ANG_W) r = ANG_W'(w >> ANG_SH);
    else r = ANG_W'(w) << ANG_SH;
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] ang_out(input logic [ANG_W-1:0] a);
    logic [COORD_W-1:0] r;
    if (COORD_W >= ANG_W) r = COORD_W'(a) << ANG_SH;
    else r = COORD_W'(a >> ANG_SH);
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: sv/ccv_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccv_stage
// One registered CORDIC micro-rotation, vectoring or rotation per item.
// ----------------------------------------------------------------------------
module ccv_stage
  import ccv_pkg::*;
#(
  parameter int               SHIFT = 0,
  parameter logic [ANG_W-1:0] ATAN  = '0
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      en,
  input  wire logic      up_valid,
  input  wire ccv_item_t up,
  output logic           dn_valid,
  output ccv_item_t      dn
);

  ccv_item_t            dn_next;
  logic signed [IW-1:0] dx;
  logic signed [IW-1:0] dy;
  logic                 ccw;

  always_comb begin
    dx  = up.x >>> SHIFT;
    dy  = up.y >>> SHIFT;
    // rotation drives the residual angle to zero, vectoring drives y to zero
    ccw = up.rot ? !up.ang[ANG_W-1] : !(up.y > 0);
    dn_next = up;
    if (ccw) begin
      dn_next.x   = up.x - dy;
      dn_next.y   = up.y + dx;
      dn_next.ang = up.ang - ATAN;
    end else begin
      dn_next.x   = up.x + dy;
      dn_next.y   = up.y - dx;
      dn_next.ang = up.ang + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (en) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dn <= dn_next;
    end
  end

endmodule
`default_nettype wire

FILE: sv/ccv_gain.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccv_gain
// Three-stage removal of the CORDIC gain from x and y, rounding half away from zero.
// ----------------------------------------------------------------------------
module ccv_gain
  import ccv_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      en,
  input  wire logic      up_valid,
  input  wire ccv_item_t up,
  output logic           dn_valid,
  output ccv_item_t      dn
);

  logic            v1;
  logic            v2;
  ccv_item_t       it1;
  ccv_item_t       it2;
  logic            negx1;
  logic            negy1;
  logic            negx2;
  logic            negy2;
  logic [IW-1:0]   magx;
  logic [IW-1:0]   magy;
  logic [IW-1:0]   hx;
  logic [IW-1:0]   lx;
  logic [IW-1:0]   hy;
  logic [IW-1:0]   ly;
  logic [IW-1:0]   rx;
  logic [IW-1:0]   ry;
  ccv_item_t       dn_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      dn_valid <= 1'b0;
    end else if (en) begin
      v1       <= up_valid;
      v2       <= v1;
      dn_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it1   <= up;
      negx1 <= up.x < 0;
      negy1 <= up.y < 0;
      magx  <= (up.x < 0) ? IW'(-up.x) : IW'(up.x);
      magy  <= (up.y < 0) ? IW'(-up.y) : IW'(up.y);
      it2   <= it1;
      negx2 <= negx1;
      negy2 <= negy1;
      hx    <= magx[IW-1:32] * INV_GAIN;
      lx    <= magx[31:0] * INV_GAIN;
      hy    <= magy[IW-1:32] * INV_GAIN;
      ly    <= magy[31:0] * INV_GAIN;
      dn    <= dn_next;
    end
  end

  always_comb begin
    rx = hx + ((lx + IW'(32'h80000000)) >> 32);
    ry = hy + ((ly + IW'(32'h80000000)) >> 32);
    dn_next   = it2;
    dn_next.x = negx2 ? -signed'(rx) : signed'(rx);
    dn_next.y = negy2 ? -signed'(ry) : signed'(ry);
  end

endmodule
`default_nettype wire

FILE: sv/ccv_pass.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccv_pass
// One full CORDIC pass: a chain of micro-rotation stages and gain removal.
// ----------------------------------------------------------------------------
module ccv_pass
  import ccv_pkg::*;
#(
  parameter int ITER = CORDIC_ITER
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      en,
  input  wire logic      up_valid,
  input  wire ccv_item_t up,
  output logic           dn_valid,
  output ccv_item_t      dn
);

  logic      chain_v [ITER+1];
  ccv_item_t chain   [ITER+1];
  ccv_item_t gout;

  assign chain_v[0] = up_valid;
  assign chain[0]   = up;

  for (genvar i = 0; i < ITER; i++) begin : g_stage
    ccv_stage #(
      .SHIFT (i),
      .ATAN  (atan_val(i))
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .up_valid (chain_v[i]),
      .up       (chain[i]),
      .dn_valid (chain_v[i+1]),
      .dn       (chain[i+1])
    );
  end

  ccv_gain u_gain (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .up_valid (chain_v[ITER]),
    .up       (chain[ITER]),
    .dn_valid (dn_valid),
    .dn       (gout)
  );

  // a zero vector has angle zero
  always_comb begin
    dn = gout;
    if (gout.zero && !gout.rot) begin
      dn.ang = '0;
    end
  end

endmodule
`default_nettype wire

FILE: sv/coordinate_system_convert.sv
`default_nettype none
// ----------------------------------------------------------------------------
// coordinate_system_convert
// Cartesian, polar/cylindrical and spherical conversion by pipelined CORDIC.
// ----------------------------------------------------------------------------
// Takes one item per clock and returns one result per item, in order. Every
// item goes through a setup stage, a first CORDIC pass, a second setup stage,
// a second CORDIC pass and an output stage; each pass is CORDIC_ITERATIONS
// micro-rotation stages plus three gain-removal stages. Commands that need one
// pass still flow through both. When the output is not taken the whole
// pipeline holds, so throughput is one item per cycle whenever rsp_ready
// stays high.
module coordinate_system_convert
  import ccv_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = CORDIC_ITER
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_ready,
  input  wire ccv_req_t req,
  output logic          rsp_valid,
  input  wire logic     rsp_ready,
  output ccv_rsp_t      rsp
);

  logic      en;
  logic      s0_valid;
  ccv_item_t s0;
  ccv_item_t s0_next;
  logic      p1_valid;
  ccv_item_t p1;
  logic      s1_valid;
  ccv_item_t s1;
  ccv_item_t s1_next;
  logic      p2_valid;
  ccv_item_t p2;
  ccv_rsp_t  rsp_next;

  assign en        = !rsp_valid || rsp_ready;
  assign req_ready = en;

  // first setup: vectoring of (x, y) or rotation of (rho, 0)
  always_comb begin
    logic signed [IW-1:0] xa;
    logic signed [IW-1:0] yb;
    logic [ANG_W-1:0]     a;
    logic [ANG_W-1:0]     t;
    xa = len_in(req.in_a);
    yb = len_in(req.in_b);
    a  = (req.cmd == CMD_POLAR_CART) ? ang_in(req.in_b) : ang_in(req.in_c);
    t  = a + QUARTER_TURN;
    s0_next      = '0;
    s0_next.cmd  = req.cmd;
    s0_next.pb   = req.in_b;
    s0_next.pc   = req.in_c;
    s0_next.rot  = req.cmd[0];
    if (req.cmd[0]) begin
      s0_next.x   = xa;
      s0_next.y   = '0;
      s0_next.ang = a;
      if (t[ANG_W-1]) begin
        s0_next.x   = -xa;
        s0_next.ang = a + HALF_TURN;
      end
    end else begin
      s0_next.zero = (xa == 0) && (yb == 0);
      s0_next.x    = xa;
      s0_next.y    = yb;
      if (xa < 0) begin
        s0_next.x   = -xa;
        s0_next.y   = -yb;
        s0_next.ang = HALF_TURN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0 <= s0_next;
    end
  end

  ccv_pass #(.ITER(CORDIC_ITERATIONS)) u_pass1 (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .up_valid (s0_valid),
    .up       (s0),
    .dn_valid (p1_valid),
    .dn       (p1)
  );

  // second setup: phi from (z, rho_xy), or rotate (rho sin phi, 0) by theta
  always_comb begin
    logic signed [IW-1:0] zl;
    logic [ANG_W-1:0]     a;
    logic [ANG_W-1:0]     t;
    zl = len_in(p1.pc);
    a  = ang_in(p1.pb);
    t  = a + QUARTER_TURN;
    s1_next      = '0;
    s1_next.cmd  = p1.cmd;
    s1_next.pb   = p1.pb;
    s1_next.pc   = p1.pc;
    s1_next.sx   = p1.x;
    s1_next.sy   = p1.y;
    s1_next.sth  = p1.ang;
    case (p1.cmd)
      CMD_CART_SPHER: begin
        s1_next.zero = (zl == 0) && (p1.x == 0);
        s1_next.x    = zl;
        s1_next.y    = p1.x;
        if (zl < 0) begin
          s1_next.x   = -zl;
          s1_next.y   = -p1.x;
          s1_next.ang = HALF_TURN;
        end
      end
      CMD_SPHER_CART: begin
        s1_next.rot = 1'b1;
        s1_next.x   = p1.y;
        s1_next.ang = a;
        if (t[ANG_W-1]) begin
          s1_next.x   = -p1.y;
          s1_next.ang = a + HALF_TURN;
        end
      end
      default: begin
        s1_next.rot = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= s1_next;
    end
  end

  ccv_pass #(.ITER(CORDIC_ITERATIONS)) u_pass2 (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .up_valid (s1_valid),
    .up       (s1),
    .dn_valid (p2_valid),
    .dn       (p2)
  );

  // output: rounding, saturation and field selection
  always_comb begin
    ccv_len_t la;
    ccv_len_t lb;
    ccv_len_t lc;
    la = len_out(p2.cmd[1] ? p2.x : p2.sx);
    lb = len_out(p2.cmd[1] ? p2.y : p2.sy);
    lc = len_out(p2.sx);
    rsp_next.out_a    = la.val;
    rsp_next.out_b    = p2.cmd[0] ? lb.val : ang_out(p2.sth);
    rsp_next.overflow = la.ovf | (p2.cmd[0] & lb.ovf);
    case (p2.cmd)
      CMD_CART_SPHER: rsp_next.out_c = ang_out(p2.ang);
      CMD_SPHER_CART: begin
        rsp_next.out_c    = lc.val;
        rsp_next.overflow = la.ovf | lb.ovf | lc.ovf;
      end
      default: rsp_next.out_c = p2.pc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en) begin
      rsp_valid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp <= rsp_next;
    end
  end

  a_stall_holds_passes: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(p1_valid) && $stable(p2_valid) && $stable(s0_valid))
    else $error("pipeline moved during an output stall");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> s0_valid)
    else $error("accepted item missing from setup stage");

  a_vector_x_nonneg: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && !req.cmd[0] |=> s0.x >= 0)
    else $error("vectoring setup left x negative");

  a_z_passes: assert property (@(posedge clk) disable iff (rst)
    en && p2_valid && (p2.cmd == CMD_CART_POLAR || p2.cmd == CMD_POLAR_CART)
    |=> rsp.out_c == $past(p2.pc))
    else $error("z not passed through");

endmodule
`default_nettype wire
